@@ rtl/bts_pkg.sv @@
`default_nettype none

package bts_pkg;

  typedef enum logic [2:0] {
    MODE_EXPECT     = 3'd0,
    MODE_STRLEN     = 3'd1,
    MODE_STRBODY    = 3'd2,
    MODE_INT_FIRST  = 3'd3,
    MODE_INT_SIGNED = 3'd4,
    MODE_INT_DIGITS = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STRLEN  = 3'd1,
    EV_STRBYTE = 3'd2,
    EV_INT     = 3'd3,
    EV_LIST    = 3'd4,
    EV_DICT    = 3'd5,
    EV_CLOSE   = 3'd6,
    EV_ERROR   = 3'd7
  } ev_e;

  // stack entry: bit 0 dictionary, bit 1 key expected next
  localparam logic [1:0] ENT_LIST     = 2'b00;
  localparam logic [1:0] ENT_DICT_VAL = 2'b01;
  localparam logic [1:0] ENT_DICT_KEY = 2'b11;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [35:0] POS_LIMIT = 36'd2147483647;
  localparam logic [35:0] NEG_LIMIT = 36'd2147483648;

  typedef struct packed {
    ev_e                event_res;
    logic signed [31:0] value;
    logic [7:0]         byte_out;
    logic [5:0]         nest_depth;
    logic               is_key;
    logic               element_end;
    logic               top_done;
    logic [31:0]        byte_offset;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bts_in_if.sv @@
`default_nettype none

interface bts_in_if
  import bts_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

@@ rtl/bts_out_if.sv @@
`default_nettype none

interface bts_out_if
  import bts_pkg::*;
;
  logic               valid;
  logic               ready;
  ev_e                event_res;
  logic signed [31:0] value;
  logic [7:0]         byte_out;
  logic [5:0]         nest_depth;
  logic               is_key;
  logic               element_end;
  logic               top_done;
  logic [31:0]        byte_offset;

  modport source (
    output valid, output event_res, output value, output byte_out, output nest_depth,
    output is_key, output element_end, output top_done, output byte_offset,
    input ready
  );
  modport sink (
    input valid, input event_res, input value, input byte_out, input nest_depth,
    input is_key, input element_end, input top_done, input byte_offset,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/bts_stack_mem.sv @@
`default_nettype none

module bts_stack_mem
  import bts_pkg::*;
#(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [1:0]       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [1:0]       rdata_o
);

  logic [1:0] stack_q [Depth];
  logic [1:0] rdata_q;
  logic [1:0] byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stack_q[waddr_i] <= wdata_i;
    end
    rdata_q    <= stack_q[raddr_i];
    byp_data_q <= wdata_i;
  end

  // write-to-read forwarding on the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rdata_q;

endmodule

`default_nettype wire

@@ rtl/bts_core.sv @@
`default_nettype none

module bts_core
  import bts_pkg::*;
#(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       key_check_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_data_byte_i,
  input  wire logic       in_restart_i,
  output      logic       in_ready_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      res_t       out_res_o
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  mode_e        mode_q, mode_d, mode_c;
  logic [31:0]  acc_q, acc_d, acc_c;
  logic         neg_q, neg_d, neg_c;
  logic [30:0]  left_q, left_d;
  logic [DW-1:0] dep_q, dep_d, dep_c;
  logic [1:0]   tos_q, tos_d;
  logic [31:0]  off_q, off_c;
  logic         err_q, err_c;
  logic         out_valid_q;
  res_t         res_q;

  logic         accept;
  logic [7:0]   b;
  logic         digit, is_i, is_l, is_d, is_e, is_colon, is_minus;
  logic [3:0]   dval;
  logic [35:0]  acc_mul;
  logic [35:0]  lim;
  logic         ovf;
  logic         kp, kp_pop, full;
  logic [1:0]   nxt;
  logic [1:0]   base;

  ev_e          ev;
  logic [31:0]  val;
  logic         key, ende, fin, push, pop, err;
  logic [DW-1:0] dep_n;

  logic          mem_we;
  logic [DW:0]   waddr_full, raddr_full;
  logic [DW-1:0] raddr_dep;
  logic [DW+5:0] dep_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign b        = in_data_byte_i;
  assign digit    = (b >= CH_0) && (b <= CH_9);
  assign dval     = digit ? 4'(b - CH_0) : 4'd0;
  assign is_i     = (b == CH_I);
  assign is_l     = (b == CH_L);
  assign is_d     = (b == CH_D);
  assign is_e     = (b == CH_E);
  assign is_colon = (b == CH_COLON);
  assign is_minus = (b == CH_MINUS);

  // restart clears everything before the byte is taken
  assign mode_c = in_restart_i ? MODE_EXPECT : mode_q;
  assign acc_c  = in_restart_i ? 32'd0 : acc_q;
  assign neg_c  = in_restart_i ? 1'b0 : neg_q;
  assign dep_c  = in_restart_i ? '0 : dep_q;
  assign err_c  = in_restart_i ? 1'b0 : err_q;
  assign off_c  = in_restart_i ? 32'd0 : off_q;

  assign acc_mul = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0} + {32'd0, dval};
  assign lim     = (mode_c == MODE_INT_DIGITS && neg_c) ? NEG_LIMIT : POS_LIMIT;
  assign ovf     = acc_mul > lim;

  assign kp     = (dep_c != '0) && (tos_q == ENT_DICT_KEY);
  assign kp_pop = (dep_c > DW'(1)) && (nxt == ENT_DICT_KEY);
  assign full   = (dep_c == DW'(MAX_DEPTH));

  // token decode and actions
  always_comb begin
    ev   = EV_NONE;
    val  = 32'd0;
    key  = 1'b0;
    ende = 1'b0;
    fin  = 1'b0;
    push = 1'b0;
    pop  = 1'b0;
    err  = 1'b0;
    if (err_c) begin
      err = 1'b1;
    end else begin
      case (mode_c)
        MODE_EXPECT: begin
          if (digit) begin
            key = kp;
          end else if (is_i || is_l || is_d) begin
            if (kp && key_check_i) begin
              err = 1'b1;
            end else if (is_i) begin
              key = kp;
            end else if (full) begin
              err = 1'b1;
            end else begin
              push = 1'b1;
              ev   = is_d ? EV_DICT : EV_LIST;
              key  = kp;
            end
          end else if (is_e && dep_c != '0) begin
            if (tos_q == ENT_DICT_VAL) begin
              err = 1'b1;
            end else begin
              pop  = 1'b1;
              ev   = EV_CLOSE;
              key  = kp_pop;
              ende = 1'b1;
              fin  = 1'b1;
            end
          end else begin
            err = 1'b1;
          end
        end
        MODE_STRLEN: begin
          key = kp;
          if (digit) begin
            err = ovf;
          end else if (is_colon) begin
            ev  = EV_STRLEN;
            val = acc_c;
            if (acc_c == 32'd0) begin
              ende = 1'b1;
              fin  = 1'b1;
            end
          end else begin
            err = 1'b1;
          end
        end
        MODE_STRBODY: begin
          key = kp;
          ev  = EV_STRBYTE;
          if (left_q == 31'd1) begin
            ende = 1'b1;
            fin  = 1'b1;
          end
        end
        MODE_INT_FIRST, MODE_INT_SIGNED: begin
          key = kp;
          if (!digit && !(is_minus && mode_c == MODE_INT_FIRST)) begin
            err = 1'b1;
          end
        end
        MODE_INT_DIGITS: begin
          key = kp;
          if (digit) begin
            err = (acc_c == 32'd0) || ovf;
          end else if (is_e) begin
            if (neg_c && acc_c == 32'd0) begin
              err = 1'b1;
            end else begin
              ev   = EV_INT;
              val  = neg_c ? (32'd0 - acc_c) : acc_c;
              ende = 1'b1;
              fin  = 1'b1;
            end
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
    if (err) begin
      ev   = EV_ERROR;
      val  = 32'd0;
      key  = 1'b0;
      ende = 1'b0;
      fin  = 1'b0;
      push = 1'b0;
      pop  = 1'b0;
    end
  end

  // next parse state
  always_comb begin
    mode_d = mode_c;
    acc_d  = acc_c;
    neg_d  = neg_c;
    left_d = in_restart_i ? 31'd0 : left_q;
    if (!err) begin
      case (mode_c)
        MODE_EXPECT: begin
          if (digit) begin
            acc_d  = {28'd0, dval};
            mode_d = MODE_STRLEN;
          end else if (is_i) begin
            acc_d  = 32'd0;
            neg_d  = 1'b0;
            mode_d = MODE_INT_FIRST;
          end
        end
        MODE_STRLEN: begin
          if (digit) begin
            acc_d = acc_mul[31:0];
          end else if (is_colon) begin
            left_d = acc_c[30:0];
            if (acc_c != 32'd0) begin
              mode_d = MODE_STRBODY;
            end
          end
        end
        MODE_STRBODY: begin
          left_d = left_q - 31'd1;
        end
        MODE_INT_FIRST, MODE_INT_SIGNED: begin
          if (digit) begin
            acc_d  = {28'd0, dval};
            mode_d = MODE_INT_DIGITS;
          end else if (is_minus) begin
            neg_d  = 1'b1;
            mode_d = MODE_INT_SIGNED;
          end
        end
        MODE_INT_DIGITS: begin
          if (digit) begin
            acc_d = acc_mul[31:0];
          end
        end
        default: begin
          mode_d = mode_c;
        end
      endcase
      if (fin) begin
        mode_d = MODE_EXPECT;
      end
    end
  end

  // container stack: top entry in tos_q, the rest in memory
  always_comb begin
    dep_n = dep_c;
    if (push) begin
      dep_n = dep_c + DW'(1);
    end else if (pop) begin
      dep_n = dep_c - DW'(1);
    end
    base = pop ? nxt : tos_q;
    if (push) begin
      tos_d = is_d ? ENT_DICT_KEY : ENT_LIST;
    end else if (fin && dep_n != '0) begin
      tos_d = base ^ {base[0], 1'b0};
    end else begin
      tos_d = base;
    end
  end

  assign dep_d      = dep_n;
  assign mem_we     = accept && push && (dep_c != '0);
  assign waddr_full = {1'b0, dep_c} - (DW + 1)'(1);
  assign raddr_dep  = accept ? dep_n : dep_q;
  assign raddr_full = {1'b0, raddr_dep} - (DW + 1)'(2);

  bts_stack_mem #(
    .Depth (MAX_DEPTH),
    .AddrW (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (waddr_full[AW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (nxt)
  );

  assign dep_ext = {6'd0, dep_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_EXPECT;
      acc_q       <= 32'd0;
      neg_q       <= 1'b0;
      left_q      <= 31'd0;
      dep_q       <= '0;
      tos_q       <= ENT_LIST;
      off_q       <= 32'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        acc_q       <= acc_d;
        neg_q       <= neg_d;
        left_q      <= left_d;
        dep_q       <= dep_d;
        tos_q       <= tos_d;
        off_q       <= off_c + 32'd1;
        err_q       <= err_c || err;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.event_res   <= ev;
      res_q.value       <= $signed(val);
      res_q.byte_out    <= b;
      res_q.nest_depth  <= dep_ext[5:0];
      res_q.is_key      <= key;
      res_q.element_end <= ende;
      res_q.top_done    <= fin && (dep_n == '0);
      res_q.byte_offset <= off_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= DW'(MAX_DEPTH))
    else $error("stack depth beyond bound");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_restart_i && err_q) |=> err_q)
    else $error("error latch cleared without restart");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result");

  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STRBODY) |-> (left_q != 31'd0))
    else $error("string body with no bytes left");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.event_res == EV_ERROR) |->
      (res_q.value == 32'sd0 && !res_q.element_end && !res_q.top_done))
    else $error("error result carries token data");
`endif

endmodule

`default_nettype wire

@@ rtl/bencode_stream_tokenizer_top.sv @@
// Bencode tokenizer: takes one stream byte per transaction and returns one token
// transaction for it, one byte per clock sustained while the sink takes each result,
// with the result registered; the input keeps flowing while a result waits as long
// as the sink takes it in the same cycle. Open containers live in a MAX_DEPTH x 2-bit
// synchronous stack memory; the top entry is held in a register and the entry
// beneath it is prefetched each cycle with write-to-read forwarding, so push and
// pop on consecutive bytes need no stall. Stack entries need no clearing pass.
// Errors are sticky until a byte with restart set.
`default_nettype none

module bencode_stream_tokenizer_top
  import bts_pkg::*;
#(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  bts_in_if.sink     in_i,
  bts_out_if.source  out_o
);

  logic key_check_q;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_check_q <= 1'b1;
    end else if (cfg_we_i) begin
      key_check_q <= cfg_wdata_i;
    end
  end

  bts_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_check_i    (key_check_q),
    .in_valid_i     (in_i.valid),
    .in_data_byte_i (in_i.data_byte),
    .in_restart_i   (in_i.restart),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_res_o      (res)
  );

  assign out_o.event_res   = res.event_res;
  assign out_o.value       = res.value;
  assign out_o.byte_out    = res.byte_out;
  assign out_o.nest_depth  = res.nest_depth;
  assign out_o.is_key      = res.is_key;
  assign out_o.element_end = res.element_end;
  assign out_o.top_done    = res.top_done;
  assign out_o.byte_offset = res.byte_offset;

endmodule

`default_nettype wire
